[sv/clm_pkg.sv]
// ----------------------------------------------------------------------------
// clm_pkg - camera look and move shared definitions
// Word formats, operation and direction codes, register indexes, the CORDIC
// arctangent table and the small helpers used by the camera datapath.
// ----------------------------------------------------------------------------
package clm_pkg;

   // formats
   localparam int AngW   = 17;            // degrees, 8 fractional bits
   localparam int MulW   = 33;            // shared multiplier operand width
   localparam int ProdW  = 2 * MulW;      // shared multiplier product width
   localparam int CsrW   = 16;
   localparam int AtanCount = 24;

   localparam logic [AngW-1:0] TURN        = 17'd92160;
   localparam logic [AngW-1:0] YAW_RESET   = 17'd69120;
   localparam logic signed [15:0] PITCH_LIM = 16'sd22784;
   localparam logic signed [15:0] VEC_ONE   = 16'sd16384;

   // CORDIC start value (gain compensated), Q30
   localparam logic signed [MulW-1:0] CORDIC_X0 = 33'sd652032875;

   // angle to binary angle: a*2^32/92160 = a*2^21/45; a/45 by reciprocal
   localparam int BamDiv   = 45;
   localparam int RecipM   = 186414;      // ceil(2^23/45)
   localparam int RecipSh  = 23;

   // configuration registers
   localparam logic [15:0] SENS_RESET  = 16'd6554;
   localparam logic [15:0] SPEED_RESET = 16'd1280;

   typedef enum logic {
      REG_LOOK_SENSITIVITY = 1'b0,
      REG_MOVE_SPEED       = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_LOOK = 1'b0,
      OP_MOVE = 1'b1
   } op_type;

   localparam logic [2:0] DIR_FWD   = 3'd0;
   localparam logic [2:0] DIR_BACK  = 3'd1;
   localparam logic [2:0] DIR_LEFT  = 3'd2;
   localparam logic [2:0] DIR_RIGHT = 3'd3;
   localparam logic [2:0] DIR_UP    = 3'd4;
   localparam logic [2:0] DIR_DOWN  = 3'd5;

   typedef struct packed {
      logic               op;
      logic signed [15:0] look_dx;
      logic signed [15:0] look_dy;
      logic [2:0]         move_dir;
      logic [15:0]        move_dt;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_type;

   // fractional part of the binary angle for each remainder of a/45
   typedef logic [20:0] frac_tab_type [0:BamDiv-1];

   function automatic frac_tab_type build_frac_tab();
      frac_tab_type t;
      for (int r = 0; r < BamDiv; r++) begin
         t[r] = 21'(((64'(r) << 21) + 64'd22) / 64'd45);
      end
      return t;
   endfunction

   // arctangent of 2^-i, 2^32 units per turn
   function automatic logic [29:0] atan_val(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:    v = 30'd536870912;
         5'd1:    v = 30'd316933406;
         5'd2:    v = 30'd167458907;
         5'd3:    v = 30'd85004756;
         5'd4:    v = 30'd42667331;
         5'd5:    v = 30'd21354465;
         5'd6:    v = 30'd10679838;
         5'd7:    v = 30'd5340245;
         5'd8:    v = 30'd2670163;
         5'd9:    v = 30'd1335087;
         5'd10:   v = 30'd667544;
         5'd11:   v = 30'd333772;
         5'd12:   v = 30'd166886;
         5'd13:   v = 30'd83443;
         5'd14:   v = 30'd41722;
         5'd15:   v = 30'd20861;
         5'd16:   v = 30'd10430;
         5'd17:   v = 30'd5215;
         5'd18:   v = 30'd2608;
         5'd19:   v = 30'd1304;
         5'd20:   v = 30'd652;
         5'd21:   v = 30'd326;
         5'd22:   v = 30'd163;
         5'd23:   v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // clamp a rounded vector component to +-1.0 in Q2.14
   function automatic logic signed [15:0] clamp_vec(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd16384) begin
         r = VEC_ONE;
      end else if (v < -20'sd16384) begin
         r = -VEC_ONE;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[sv/clm_mul.sv]
// ----------------------------------------------------------------------------
// clm_mul - shared signed multiplier
// One signed 33x33 multiply per cycle with the product registered; every
// product of the camera top level goes through this unit in turn.
// ----------------------------------------------------------------------------
module clm_mul (
   input  logic                                clock,
   input  logic signed [clm_pkg::MulW-1:0]     mul_a,
   input  logic signed [clm_pkg::MulW-1:0]     mul_b,
   output logic signed [clm_pkg::ProdW-1:0]    prod
);

   logic signed [clm_pkg::ProdW-1:0] prod_ff;
   logic signed [clm_pkg::ProdW-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[sv/clm_cordic.sv]
// ----------------------------------------------------------------------------
// clm_cordic - iterative sine and cosine
// Converts a degree angle to a binary angle, folds it into +-90 degrees and
// runs one CORDIC rotation per cycle through a single shift/add unit.
// ----------------------------------------------------------------------------
module clm_cordic #(
   parameter int STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [clm_pkg::AngW-1:0]          angle,
   output logic                              done,
   output logic signed [clm_pkg::MulW-1:0]   cos_val,
   output logic signed [clm_pkg::MulW-1:0]   sin_val
);

   localparam int IdxW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(STEPS - 1);
   localparam clm_pkg::frac_tab_type FracTab = clm_pkg::build_frac_tab();

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_DIV  = 4'b0010,
      C_ROT  = 4'b0100,
      C_OUT  = 4'b1000
   } cstate_type;

   cstate_type state_ff, state_in;
   logic [clm_pkg::AngW-1:0]        a_ff, a_in;
   logic [10:0]                     q_ff, q_in;
   logic [IdxW-1:0]                 i_ff, i_in;
   logic                            neg_ff, neg_in;
   logic signed [clm_pkg::MulW-1:0] x_ff, x_in;
   logic signed [clm_pkg::MulW-1:0] y_ff, y_in;
   logic signed [clm_pkg::MulW-1:0] z_ff, z_in;
   logic                            init_ff, init_in;

   logic [35:0]                     qprod;
   logic [clm_pkg::AngW-1:0]        rem17;
   logic [31:0]                     zraw;
   logic signed [31:0]              zs;
   logic                            fold;
   logic signed [clm_pkg::MulW-1:0] x_sh, y_sh, atan_ext;

   assign qprod    = 36'(a_ff) * 36'(clm_pkg::RecipM);
   assign rem17    = a_ff - 17'(17'(q_ff) * 17'(clm_pkg::BamDiv));
   assign zraw     = {q_ff, FracTab[rem17[5:0]]};
   assign zs       = signed'(zraw);
   assign fold     = (zs > 32'sd1073741824) || (zs < -32'sd1073741824);
   assign x_sh     = x_ff >>> i_ff;
   assign y_sh     = y_ff >>> i_ff;
   assign atan_ext = signed'(33'(clm_pkg::atan_val(5'(i_ff))));

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      q_in     = q_ff;
      i_in     = i_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      init_in  = init_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               a_in     = angle;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            q_in     = qprod[clm_pkg::RecipSh +: 11];
            init_in  = 1'b1;
            state_in = C_ROT;
         end
         C_ROT: begin
            if (init_ff) begin
               // load the folded binary angle, then rotate
               x_in    = clm_pkg::CORDIC_X0;
               y_in    = '0;
               z_in    = 33'(signed'({zraw[31] ^ fold, zraw[30:0]}));
               neg_in  = fold;
               i_in    = '0;
               init_in = 1'b0;
            end else begin
               if (!z_ff[clm_pkg::MulW-1]) begin
                  x_in = x_ff - y_sh;
                  y_in = y_ff + x_sh;
                  z_in = z_ff - atan_ext;
               end else begin
                  x_in = x_ff + y_sh;
                  y_in = y_ff - x_sh;
                  z_in = z_ff + atan_ext;
               end
               if (i_ff == LastIdx) begin
                  state_in = C_OUT;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         C_OUT: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
      end
      a_ff   <= a_in;
      q_ff   <= q_in;
      i_ff   <= i_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done    = (state_ff == C_OUT);
   assign cos_val = neg_ff ? -x_ff : x_ff;
   assign sin_val = neg_ff ? -y_ff : y_ff;

endmodule

[sv/camera_look_and_move.sv]
// ----------------------------------------------------------------------------
// camera_look_and_move - first-person camera orientation and movement
// Look words update yaw and pitch and rebuild the front, right and up vectors;
// move words step the saturating position along one of those vectors.
// ----------------------------------------------------------------------------
// A look word passes through the yaw wrap and then twice through the iterative
// CORDIC unit, once for yaw and once for pitch, before the vector products.
// A move word passes through the shared multiplier for the velocity and per axis.
// One word is in work at a time; the next is taken the cycle after the result
// is queued.
// Reset is synchronous: yaw 270 degrees, pitch 0, position 0, default vectors.
// ----------------------------------------------------------------------------
module camera_look_and_move #(
   parameter int CORDIC_STEPS = 16,
   parameter int POS_WIDTH    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  clm_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output clm_pkg::rsp_type     rsp_data,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [clm_pkg::CsrW-1:0] csr_wdata
);

   localparam int MW = clm_pkg::MulW;
   localparam int PW = clm_pkg::ProdW;
   localparam int SW = POS_WIDTH + 2;
   localparam logic signed [SW-1:0] PosHi = SW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] PosLo = -PosHi - SW'(1);
   localparam logic signed [25:0] WrapBias = 26'(128 * 92160);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_LOOK     = 10'b0000000010,
      ST_WRAP     = 10'b0000000100,
      ST_YAW_GO   = 10'b0000001000,
      ST_YAW_WAIT = 10'b0000010000,
      ST_PIT_GO   = 10'b0000100000,
      ST_PIT_WAIT = 10'b0001000000,
      ST_VEC      = 10'b0010000000,
      ST_MOVE     = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]                  cnt_ff, cnt_in;
   clm_pkg::req_type            item_ff, item_in;
   logic [15:0]                 sens_ff, sens_in;
   logic [15:0]                 speed_ff, speed_in;
   logic [clm_pkg::AngW-1:0]    yaw_ff, yaw_in;
   logic signed [15:0]          pitch_ff, pitch_in;
   logic signed [25:0]          acc_ff, acc_in;
   logic signed [POS_WIDTH-1:0] pos_ff [3];
   logic signed [POS_WIDTH-1:0] pos_in [3];
   logic signed [15:0]          vec_ff [8];   // fx fy fz rx rz ux uy uz
   logic signed [15:0]          vec_in [8];
   logic signed [MW-1:0]        cy_ff, cy_in, sy_ff, sy_in;
   logic signed [MW-1:0]        cp_ff, cp_in, sp_ff, sp_in;
   logic [31:0]                 vel_ff, vel_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   clm_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [MW-1:0]        mul_a, mul_b;
   logic signed [PW-1:0]        prod;
   logic                        cordic_start, cordic_done;
   logic [clm_pkg::AngW-1:0]    cordic_angle;
   logic signed [MW-1:0]        cordic_cos, cordic_sin;

   logic signed [PW-1:0]        look_rnd, prod_rnd, nprod_rnd, move_rnd;
   logic signed [25:0]          scaled;
   logic signed [25:0]          pitch_diff;
   logic signed [25:0]          wrap_step, wrap_next;
   logic [clm_pkg::AngW-1:0]    pitch_turn;
   logic signed [15:0]          comp;
   logic                        dir_ok, dir_neg;
   logic [1:0]                  dir_grp;
   logic [1:0]                  axis;
   logic signed [17:0]          disp;
   logic signed [SW-1:0]        pos_sum;

   function automatic logic signed [15:0] q30_to_14(input logic signed [MW:0] v);
      logic signed [MW:0] t;
      t = (v + (MW+1)'(32768)) >>> 16;
      return clm_pkg::clamp_vec(t[19:0]);
   endfunction

   function automatic logic signed [SW-1:0] sat_pos(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > PosHi) begin
         r = PosHi;
      end else if (v < PosLo) begin
         r = PosLo;
      end else begin
         r = v;
      end
      return r;
   endfunction

   clm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   clm_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_val (cordic_cos),
      .sin_val (cordic_sin)
   );

   // rounding of the shared product for each use
   assign look_rnd   = (prod + PW'(128)) >>> 8;
   assign prod_rnd   = (prod + (PW'(1) <<< 45)) >>> 46;
   assign nprod_rnd  = ((-prod) + (PW'(1) <<< 45)) >>> 46;
   assign move_rnd   = (prod + (PW'(1) <<< 29)) >>> 30;
   assign scaled     = look_rnd[25:0];
   assign pitch_diff = 26'(pitch_ff) - scaled;
   assign wrap_step  = WrapBias >>> 7 <<< (3'd7 - cnt_ff);
   assign wrap_next  = (acc_ff >= wrap_step) ? acc_ff - wrap_step : acc_ff;
   assign pitch_turn = pitch_ff[15] ? 17'(17'(pitch_ff) + clm_pkg::TURN)
                                    : 17'(pitch_ff);
   assign disp       = move_rnd[17:0];
   assign axis       = 2'(cnt_ff - 3'd3);

   always_comb begin
      dir_ok  = 1'b1;
      dir_neg = 1'b0;
      dir_grp = 2'd0;
      case (item_ff.move_dir)
         clm_pkg::DIR_FWD:   dir_grp = 2'd0;
         clm_pkg::DIR_BACK:  begin dir_grp = 2'd0; dir_neg = 1'b1; end
         clm_pkg::DIR_LEFT:  begin dir_grp = 2'd1; dir_neg = 1'b1; end
         clm_pkg::DIR_RIGHT: dir_grp = 2'd1;
         clm_pkg::DIR_UP:    dir_grp = 2'd2;
         clm_pkg::DIR_DOWN:  begin dir_grp = 2'd2; dir_neg = 1'b1; end
         default:            dir_ok = 1'b0;
      endcase
   end

   // component of the chosen vector for the axis being multiplied
   always_comb begin
      comp = '0;
      case (dir_grp)
         2'd0: begin
            case (cnt_ff)
               3'd2:    comp = vec_ff[0];
               3'd3:    comp = vec_ff[1];
               default: comp = vec_ff[2];
            endcase
         end
         2'd1: begin
            case (cnt_ff)
               3'd2:    comp = vec_ff[3];
               3'd3:    comp = '0;
               default: comp = vec_ff[4];
            endcase
         end
         default: begin
            case (cnt_ff)
               3'd2:    comp = vec_ff[5];
               3'd3:    comp = vec_ff[6];
               default: comp = vec_ff[7];
            endcase
         end
      endcase
   end

   assign pos_sum = dir_neg ? SW'(pos_ff[axis]) - SW'(disp)
                            : SW'(pos_ff[axis]) + SW'(disp);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      vec_in       = vec_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      vel_in       = vel_ff;
      mul_a        = '0;
      mul_b        = '0;
      cordic_start = 1'b0;
      cordic_angle = yaw_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      sens_in  = sens_ff;
      speed_in = speed_ff;
      if (csr_write) begin
         case (csr_index)
            clm_pkg::REG_LOOK_SENSITIVITY: sens_in  = csr_wdata;
            clm_pkg::REG_MOVE_SPEED:       speed_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               cnt_in   = '0;
               state_in = (req_data.op == clm_pkg::OP_LOOK) ? ST_LOOK : ST_MOVE;
            end
         end
         ST_LOOK: begin
            if (cnt_ff == 3'd0) begin
               mul_a  = MW'(item_ff.look_dx);
               mul_b  = MW'({1'b0, sens_ff});
               cnt_in = 3'd1;
            end else if (cnt_ff == 3'd1) begin
               mul_a  = MW'(item_ff.look_dy);
               mul_b  = MW'({1'b0, sens_ff});
               acc_in = 26'(yaw_ff) + scaled;
               cnt_in = 3'd2;
            end else begin
               if (pitch_diff > 26'(clm_pkg::PITCH_LIM)) begin
                  pitch_in = clm_pkg::PITCH_LIM;
               end else if (pitch_diff < -26'(clm_pkg::PITCH_LIM)) begin
                  pitch_in = -clm_pkg::PITCH_LIM;
               end else begin
                  pitch_in = pitch_diff[15:0];
               end
               // lift a negative yaw sum above zero before the reduction
               if (acc_ff[25]) begin
                  acc_in = acc_ff + WrapBias;
               end
               cnt_in   = '0;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            // subtract turn multiples from 128 down to 1
            acc_in = wrap_next;
            if (cnt_ff == 3'd7) begin
               yaw_in   = wrap_next[clm_pkg::AngW-1:0];
               state_in = ST_YAW_GO;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_YAW_GO: begin
            cordic_start = 1'b1;
            cordic_angle = yaw_ff;
            state_in     = ST_YAW_WAIT;
         end
         ST_YAW_WAIT: begin
            if (cordic_done) begin
               cy_in    = cordic_cos;
               sy_in    = cordic_sin;
               state_in = ST_PIT_GO;
            end
         end
         ST_PIT_GO: begin
            cordic_start = 1'b1;
            cordic_angle = pitch_turn;
            state_in     = ST_PIT_WAIT;
         end
         ST_PIT_WAIT: begin
            if (cordic_done) begin
               cp_in    = cordic_cos;
               sp_in    = cordic_sin;
               cnt_in   = '0;
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = cy_ff;
                  mul_b = cp_ff;
               end
               3'd1: begin
                  mul_a     = sy_ff;
                  mul_b     = cp_ff;
                  vec_in[0] = clm_pkg::clamp_vec(prod_rnd[19:0]);
               end
               3'd2: begin
                  mul_a     = cy_ff;
                  mul_b     = sp_ff;
                  vec_in[2] = clm_pkg::clamp_vec(prod_rnd[19:0]);
               end
               3'd3: begin
                  mul_a     = sy_ff;
                  mul_b     = sp_ff;
                  vec_in[5] = clm_pkg::clamp_vec(nprod_rnd[19:0]);
               end
               default: begin
                  vec_in[7] = clm_pkg::clamp_vec(nprod_rnd[19:0]);
                  vec_in[1] = q30_to_14((MW+1)'(sp_ff));
                  vec_in[3] = q30_to_14(-((MW+1)'(sy_ff)));
                  vec_in[4] = q30_to_14((MW+1)'(cy_ff));
                  vec_in[6] = q30_to_14((MW+1)'(cp_ff));
                  state_in  = ST_DONE;
               end
            endcase
            if (cnt_ff != 3'd4) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_MOVE: begin
            case (cnt_ff)
               3'd0: begin
                  mul_a = MW'({1'b0, speed_ff});
                  mul_b = MW'({1'b0, item_ff.move_dt});
               end
               3'd1: begin
                  vel_in = prod[31:0];
               end
               default: begin
                  mul_a = MW'({1'b0, vel_ff});
                  mul_b = MW'(comp);
                  // product for axis cnt-3 is ready from cnt 3 on
                  if (cnt_ff >= 3'd3 && dir_ok) begin
                     pos_in[axis] = POS_WIDTH'(sat_pos(pos_sum));
                  end
                  if (cnt_ff == 3'd5) begin
                     state_in = ST_DONE;
                  end
               end
            endcase
            if (cnt_ff != 3'd5) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.pos_x   = 32'(pos_ff[0]);
               rsp_data_in.pos_y   = 32'(pos_ff[1]);
               rsp_data_in.pos_z   = 32'(pos_ff[2]);
               rsp_data_in.front_x = vec_ff[0];
               rsp_data_in.front_y = vec_ff[1];
               rsp_data_in.front_z = vec_ff[2];
               rsp_data_in.right_x = vec_ff[3];
               rsp_data_in.right_z = vec_ff[4];
               rsp_data_in.up_x    = vec_ff[5];
               rsp_data_in.up_y    = vec_ff[6];
               rsp_data_in.up_z    = vec_ff[7];
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sens_ff      <= clm_pkg::SENS_RESET;
         speed_ff     <= clm_pkg::SPEED_RESET;
         yaw_ff       <= clm_pkg::YAW_RESET;
         pitch_ff     <= '0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= '0;
         vec_ff[0]    <= '0;
         vec_ff[1]    <= '0;
         vec_ff[2]    <= -clm_pkg::VEC_ONE;
         vec_ff[3]    <= clm_pkg::VEC_ONE;
         vec_ff[4]    <= '0;
         vec_ff[5]    <= '0;
         vec_ff[6]    <= clm_pkg::VEC_ONE;
         vec_ff[7]    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         sens_ff      <= sens_in;
         speed_ff     <= speed_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         pos_ff       <= pos_in;
         vec_ff       <= vec_in;
      end
      item_ff     <= item_in;
      acc_ff      <= acc_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      vel_ff      <= vel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/camera_look_and_move_tb.sv]
// ----------------------------------------------------------------------------
// testbench - camera look and move
// Sends look and move words through the request channel and predicts each
// returned camera view from a fixed-point model of yaw, pitch, the CORDIC
// sine and cosine, the orientation vectors and the saturating position.
// Every response is compared field by field against the oldest predicted view.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int     CordicSteps   = 16;
   localparam int     PosWidth      = 32;
   localparam longint FullTurn      = 92160;
   localparam longint PitchMax      = 22784;
   localparam longint UnitVec       = 16384;
   localparam longint CordicGainX   = 652032875;
   localparam longint QuarterBam    = 64'sd1 <<< 30;
   localparam longint PosMax        = (64'sd1 <<< (PosWidth - 1)) - 1;
   localparam longint PosMin        = -PosMax - 1;
   localparam int     WatchdogLimit = 2000;
   localparam int     SettleCycles  = 64;
   localparam int     PhaseWords    = 190;
   localparam int     SatMoves      = 48;

   // move directions that the block treats as no motion
   localparam logic [2:0] DIR_UNDEF_LO = 3'd6;
   localparam logic [2:0] DIR_UNDEF_HI = 3'd7;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_valid  = 1'b0;
   logic                     req_stall;
   clm_pkg::req_type         req_data   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall  = 1'b0;
   clm_pkg::rsp_type         rsp_data;
   logic                     csr_write  = 1'b0;
   logic                     csr_index  = 1'b0;
   logic [clm_pkg::CsrW-1:0] csr_wdata  = '0;

   // predicted camera state
   longint cam_sens, cam_speed, cam_yaw, cam_pitch;
   longint cam_pos [3];
   longint cam_vec [8];   // front x y z, right x z, up x y z

   clm_pkg::req_type pending_words [$];
   clm_pkg::rsp_type expected_views [$];
   clm_pkg::rsp_type want_view;

   bit word_taken = 1'b0;
   int idle_cycles = 0;
   int failures = 0;
   int burst_left = 0, gap_left = 0, gap_pick;
   int stall_left = 0, flow_left = 0;
   int look_count = 0, move_count = 0, still_moves = 0, csr_count = 0;
   int pitch_limits = 0, yaw_wraps = 0, saturated_views = 0, views_checked = 0;

   camera_look_and_move #(
      .CORDIC_STEPS(CordicSteps),
      .POS_WIDTH   (PosWidth)
   ) u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_write,
      .csr_index,
      .csr_wdata
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint bound(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // arctangent of 2^-i, 2^32 units per turn
   function automatic longint arctan_bam(input int i);
      case (i)
         0:       return 536870912;
         1:       return 316933406;
         2:       return 167458907;
         3:       return 85004756;
         4:       return 42667331;
         5:       return 21354465;
         6:       return 10679838;
         7:       return 5340245;
         8:       return 2670163;
         9:       return 1335087;
         10:      return 667544;
         11:      return 333772;
         12:      return 166886;
         13:      return 83443;
         14:      return 41722;
         15:      return 20861;
         16:      return 10430;
         17:      return 5215;
         18:      return 2608;
         19:      return 1304;
         20:      return 652;
         21:      return 326;
         22:      return 163;
         23:      return 81;
         default: return 0;
      endcase
   endfunction

   function automatic void sin_cos_deg(input longint ang, output longint cos_q30,
                                       output longint sin_q30);
      longint x, y, z, nx;
      bit flip;
      x = CordicGainX;
      y = 0;
      flip = 1'b0;
      if (ang < 0) ang += FullTurn;
      z = ((ang <<< 32) + FullTurn / 2) / FullTurn;
      if (z >= 2 * QuarterBam) z -= 4 * QuarterBam;
      // fold into +-90 degrees, negate both results afterwards
      if (z > QuarterBam) begin
         z -= 2 * QuarterBam;
         flip = 1'b1;
      end else if (z < -QuarterBam) begin
         z += 2 * QuarterBam;
         flip = 1'b1;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= arctan_bam(i);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += arctan_bam(i);
         end
         x = nx;
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
   endfunction

   function automatic longint to_q14(input longint v);
      return bound(round_shift(v, 16), -UnitVec, UnitVec);
   endfunction

   function automatic longint mul_q14(input longint a, input longint b);
      return bound(round_shift(a * b, 46), -UnitVec, UnitVec);
   endfunction

   function automatic void camera_reset();
      cam_sens  = clm_pkg::SENS_RESET;
      cam_speed = clm_pkg::SPEED_RESET;
      cam_yaw   = 69120;
      cam_pitch = 0;
      cam_pos   = '{0, 0, 0};
      cam_vec   = '{0, 0, -UnitVec, UnitVec, 0, 0, UnitVec, 0};
   endfunction

   function automatic clm_pkg::rsp_type camera_predict(input clm_pkg::req_type w);
      longint dx, dy, shift_x, shift_y, yaw_raw, pitch_raw;
      longint cos_yaw, sin_yaw, cos_pitch, sin_pitch, dt, vel, d;
      longint comp [3];
      int sense;
      clm_pkg::rsp_type r;
      if (w.op == clm_pkg::OP_LOOK) begin
         look_count++;
         dx = w.look_dx;
         dy = w.look_dy;
         shift_x = round_shift(dx * cam_sens, 8);
         shift_y = round_shift(dy * cam_sens, 8);
         yaw_raw = cam_yaw + shift_x;
         if (yaw_raw < 0 || yaw_raw >= FullTurn) yaw_wraps++;
         cam_yaw = yaw_raw % FullTurn;
         if (cam_yaw < 0) cam_yaw += FullTurn;
         pitch_raw = cam_pitch - shift_y;
         if (pitch_raw > PitchMax || pitch_raw < -PitchMax) pitch_limits++;
         cam_pitch = bound(pitch_raw, -PitchMax, PitchMax);
         sin_cos_deg(cam_yaw, cos_yaw, sin_yaw);
         sin_cos_deg(cam_pitch, cos_pitch, sin_pitch);
         cam_vec[0] = mul_q14(cos_yaw, cos_pitch);
         cam_vec[1] = to_q14(sin_pitch);
         cam_vec[2] = mul_q14(sin_yaw, cos_pitch);
         cam_vec[3] = to_q14(-sin_yaw);
         cam_vec[4] = to_q14(cos_yaw);
         cam_vec[5] = mul_q14(-cos_yaw, sin_pitch);
         cam_vec[6] = to_q14(cos_pitch);
         cam_vec[7] = mul_q14(-sin_yaw, sin_pitch);
      end else begin
         move_count++;
         dt = w.move_dt;
         vel = cam_speed * dt;
         sense = 0;
         comp = '{0, 0, 0};
         case (w.move_dir)
            clm_pkg::DIR_FWD: begin
               comp  = '{cam_vec[0], cam_vec[1], cam_vec[2]};
               sense = 1;
            end
            clm_pkg::DIR_BACK: begin
               comp  = '{cam_vec[0], cam_vec[1], cam_vec[2]};
               sense = -1;
            end
            clm_pkg::DIR_LEFT: begin
               comp  = '{cam_vec[3], 0, cam_vec[4]};
               sense = -1;
            end
            clm_pkg::DIR_RIGHT: begin
               comp  = '{cam_vec[3], 0, cam_vec[4]};
               sense = 1;
            end
            clm_pkg::DIR_UP: begin
               comp  = '{cam_vec[5], cam_vec[6], cam_vec[7]};
               sense = 1;
            end
            clm_pkg::DIR_DOWN: begin
               comp  = '{cam_vec[5], cam_vec[6], cam_vec[7]};
               sense = -1;
            end
            default: still_moves++;
         endcase
         if (sense != 0) begin
            for (int k = 0; k < 3; k++) begin
               d = round_shift(vel * comp[k], 30);
               cam_pos[k] = bound(cam_pos[k] + sense * d, PosMin, PosMax);
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (cam_pos[k] == PosMax || cam_pos[k] == PosMin) begin
            saturated_views++;
            break;
         end
      end
      r.pos_x   = 32'(cam_pos[0]);
      r.pos_y   = 32'(cam_pos[1]);
      r.pos_z   = 32'(cam_pos[2]);
      r.front_x = 16'(cam_vec[0]);
      r.front_y = 16'(cam_vec[1]);
      r.front_z = 16'(cam_vec[2]);
      r.right_x = 16'(cam_vec[3]);
      r.right_z = 16'(cam_vec[4]);
      r.up_x    = 16'(cam_vec[5]);
      r.up_y    = 16'(cam_vec[6]);
      r.up_z    = 16'(cam_vec[7]);
      return r;
   endfunction

   // ---------------------------------------------------------------- words

   function automatic clm_pkg::req_type look_word(input logic [15:0] dx,
                                                  input logic [15:0] dy);
      clm_pkg::req_type w;
      w.op       = clm_pkg::OP_LOOK;
      w.look_dx  = dx;
      w.look_dy  = dy;
      w.move_dir = 3'($urandom);
      w.move_dt  = 16'($urandom);
      return w;
   endfunction

   function automatic clm_pkg::req_type move_word(input logic [2:0] dir,
                                                  input logic [15:0] dt);
      clm_pkg::req_type w;
      w.op       = clm_pkg::OP_MOVE;
      w.look_dx  = 16'($urandom);
      w.look_dy  = 16'($urandom);
      w.move_dir = dir;
      w.move_dt  = dt;
      return w;
   endfunction

   function automatic clm_pkg::req_type random_word();
      logic [2:0]  dir;
      logic [15:0] dt, dx, dy;
      dir = ($urandom_range(0, 15) == 0) ?
            3'($urandom_range(DIR_UNDEF_LO, DIR_UNDEF_HI)) :
            3'($urandom_range(clm_pkg::DIR_FWD, clm_pkg::DIR_DOWN));
      dt  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      dx  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800) - 400);
      dy  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800) - 400);
      if ($urandom_range(0, 1) == 1) return move_word(dir, dt);
      return look_word(dx, dy);
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic csr_store(input clm_pkg::reg_index_type idx,
                            input logic [clm_pkg::CsrW-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_views.size() != 0);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_data  <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 31);
               gap_pick   = $urandom_range(0, 7);
               gap_left   = (gap_pick < 4) ? 0 :
                            (gap_pick < 7) ? $urandom_range(1, 8) : $urandom_range(20, 70);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall a random stretch, then flow a random stretch
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left--;
      end else begin
         rsp_stall <= 1'b0;
         flow_left  = $urandom_range(1, 60);
         stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         camera_reset();
         word_taken  = 1'b0;
         idle_cycles = 0;
      end else begin
         if (csr_write) begin
            csr_count++;
            if (csr_index == clm_pkg::REG_LOOK_SENSITIVITY) cam_sens = csr_wdata;
            else if (csr_index == clm_pkg::REG_MOVE_SPEED) cam_speed = csr_wdata;
         end
         word_taken = req_valid && !req_stall;
         if (word_taken) expected_views.push_back(camera_predict(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               $error("response with no word outstanding");
               failures++;
            end else begin
               want_view = expected_views.pop_front();
               views_checked++;
               check_field("pos_x",   want_view.pos_x,   rsp_data.pos_x);
               check_field("pos_y",   want_view.pos_y,   rsp_data.pos_y);
               check_field("pos_z",   want_view.pos_z,   rsp_data.pos_z);
               check_field("front_x", want_view.front_x, rsp_data.front_x);
               check_field("front_y", want_view.front_y, rsp_data.front_y);
               check_field("front_z", want_view.front_z, rsp_data.front_z);
               check_field("right_x", want_view.right_x, rsp_data.right_x);
               check_field("right_z", want_view.right_z, rsp_data.right_z);
               check_field("up_x",    want_view.up_x,    rsp_data.up_x);
               check_field("up_y",    want_view.up_y,    rsp_data.up_y);
               check_field("up_z",    want_view.up_z,    rsp_data.up_z);
            end
         end
         if (word_taken || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
               $display("watchdog: no word moved for %0d cycles, %0d views outstanding",
                        idle_cycles, expected_views.size());
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      longint turn_dx, turn_dy;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset settings
      pending_words.push_back(look_word(16'h0000, 16'h0000));
      pending_words.push_back(move_word(clm_pkg::DIR_FWD, 16'hFFFF));
      pending_words.push_back(move_word(clm_pkg::DIR_BACK, 16'd40000));
      pending_words.push_back(move_word(clm_pkg::DIR_LEFT, 16'd40000));
      pending_words.push_back(move_word(clm_pkg::DIR_RIGHT, 16'd40000));
      pending_words.push_back(move_word(clm_pkg::DIR_UP, 16'd40000));
      pending_words.push_back(move_word(clm_pkg::DIR_DOWN, 16'd40000));
      pending_words.push_back(move_word(DIR_UNDEF_LO, 16'hFFFF));
      pending_words.push_back(move_word(DIR_UNDEF_HI, 16'hFFFF));
      pending_words.push_back(move_word(clm_pkg::DIR_FWD, 16'h0000));
      pending_words.push_back(look_word(16'h7FFF, 16'h7FFF));
      pending_words.push_back(move_word(clm_pkg::DIR_UP, 16'hFFFF));
      pending_words.push_back(move_word(clm_pkg::DIR_FWD, 16'hFFFF));
      pending_words.push_back(look_word(16'h8000, 16'h8000));
      pending_words.push_back(move_word(clm_pkg::DIR_FWD, 16'hFFFF));
      pending_words.push_back(move_word(clm_pkg::DIR_LEFT, 16'hFFFF));
      pending_words.push_back(move_word(clm_pkg::DIR_DOWN, 16'hFFFF));
      pending_words.push_back(look_word(16'h0001, 16'hFFFF));
      pending_words.push_back(look_word(16'hFFFF, 16'h0001));
      pending_words.push_back(look_word(16'd1000, 16'h0000));
      pending_words.push_back(move_word(clm_pkg::DIR_RIGHT, 16'h0001));
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_store(clm_pkg::REG_LOOK_SENSITIVITY, 16'h0000);
               csr_store(clm_pkg::REG_MOVE_SPEED, 16'h0000);
            end
            1: begin
               csr_store(clm_pkg::REG_LOOK_SENSITIVITY, 16'hFFFF);
               csr_store(clm_pkg::REG_MOVE_SPEED, 16'hFFFF);
            end
            2: begin
               csr_store(clm_pkg::REG_LOOK_SENSITIVITY, 16'h0001);
               csr_store(clm_pkg::REG_MOVE_SPEED, 16'h0001);
            end
            4: begin
               csr_store(clm_pkg::REG_LOOK_SENSITIVITY, clm_pkg::SENS_RESET);
               csr_store(clm_pkg::REG_MOVE_SPEED, clm_pkg::SPEED_RESET);
            end
            default: begin
               csr_store(clm_pkg::REG_LOOK_SENSITIVITY, 16'($urandom));
               csr_store(clm_pkg::REG_MOVE_SPEED, 16'($urandom));
            end
         endcase
         repeat (PhaseWords) pending_words.push_back(random_word());
         wait_idle();
      end

      // aim roughly at yaw 315, pitch 35 so every axis drifts, then push forward at full speed
      csr_store(clm_pkg::REG_LOOK_SENSITIVITY, 16'hFFFF);
      csr_store(clm_pkg::REG_MOVE_SPEED, 16'hFFFF);
      turn_dx = (315 * 256 - cam_yaw) / 256;
      turn_dy = (cam_pitch - 35 * 256) / 256;
      pending_words.push_back(look_word(16'(turn_dx), 16'(turn_dy)));
      repeat (SatMoves) pending_words.push_back(move_word(clm_pkg::DIR_FWD, 16'hFFFF));
      repeat (PhaseWords) pending_words.push_back(random_word());
      wait_idle();
      repeat (SettleCycles) @(posedge clock);

      $display("Run covered %0d look and %0d move words (%0d with no direction),",
               look_count, move_count, still_moves);
      $display("%0d register writes; pitch clamped %0d times, yaw wrapped %0d times,",
               csr_count, pitch_limits, yaw_wraps);
      $display("%0d of %0d views at a position rail.", saturated_views, views_checked);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
sv/clm_pkg.sv
sv/clm_mul.sv
sv/clm_cordic.sv
sv/camera_look_and_move.sv
verif/camera_look_and_move_tb.sv
